### src/burst_energy_detector_defines.svh
// Assertion macros used by the checker file.
`ifndef BURST_ENERGY_DETECTOR_DEFINES_SVH
`define BURST_ENERGY_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BED_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("burst_energy_detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define BED_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("burst_energy_detector check failed");

`endif

### src/bed_pkg.sv
package bed_pkg;

   localparam int LENGTH_BITS    = 24;
   localparam int SUM_BITS       = 40;
   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DIV_STEP_BITS  = $clog2(SUM_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] BED_REG_THRESHOLD    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] BED_REG_VALID_COUNT  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] BED_REG_POWER_ENABLE = CSR_INDEX_BITS'(2);

   localparam logic [COUNT_BITS-1:0] VALID_COUNT_RESET = COUNT_BITS'(64);

   typedef enum logic {
      BED_IDLE,
      BED_DIVIDE
   } bed_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bed_div_status_type;

endpackage

### src/bed_interfaces.sv
interface bed_req_if;
   import bed_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;
   logic signed [SAMPLE_BITS-1:0] energy;

   modport source (output valid, output sample_re, output sample_im, output energy,
                   input ready);
   modport sink (input valid, input sample_re, input sample_im, input energy,
                 output ready);
endinterface

interface bed_rsp_if;
   import bed_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic                          burst_start;
   logic                          burst_end;
   logic                          power_valid;
   logic signed [SAMPLE_BITS-1:0] avg_power;

   modport source (output valid, output out_re, output out_im, output burst_start,
                   output burst_end, output power_valid, output avg_power,
                   input ready);
   modport sink (input valid, input out_re, input out_im, input burst_start,
                 input burst_end, input power_valid, input avg_power,
                 output ready);
endinterface

### src/bed_divider.sv
module bed_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [bed_pkg::SUM_BITS-1:0]  dividend,
   input  logic [bed_pkg::LENGTH_BITS-1:0]      divisor,
   output bed_pkg::bed_div_status_type          status,
   output logic signed [bed_pkg::SAMPLE_BITS-1:0] quotient
);
   import bed_pkg::*;

   localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(2 ** (SAMPLE_BITS - 1));
   localparam logic [DIV_STEP_BITS-1:0] LAST_STEP = DIV_STEP_BITS'(SUM_BITS - 1);

   logic [SUM_BITS-1:0]      mag_ff, mag_in;
   logic [LENGTH_BITS-1:0]   rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]   div_ff, div_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [SUM_BITS-1:0]    dividend_bits;
   logic [LENGTH_BITS:0]   rem_shift;
   logic [LENGTH_BITS:0]   rem_diff;
   logic                   fits;

   always_comb begin
      dividend_bits = dividend;
      rem_shift     = {rem_ff, mag_ff[SUM_BITS-1]};
      rem_diff      = rem_shift - {1'b0, div_ff};
      fits          = (rem_shift >= {1'b0, div_ff});

      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         mag_in  = dividend_bits[SUM_BITS-1] ? (~dividend_bits + 1'b1) : dividend_bits;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         neg_in  = dividend_bits[SUM_BITS-1];
         zero_in = (divisor == '0);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[LENGTH_BITS-1:0] : rem_shift[LENGTH_BITS-1:0];
         mag_in  = {mag_ff[SUM_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (neg_ff) begin
         if (mag_ff > NEG_LIMIT) begin
            quotient = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         end else begin
            quotient = ~mag_ff[SAMPLE_BITS-1:0] + 1'b1;
         end
      end else begin
         if (mag_ff > POS_LIMIT) begin
            quotient = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
         end else begin
            quotient = mag_ff[SAMPLE_BITS-1:0];
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### src/burst_energy_detector.sv
// Burst gate on a per-sample energy stream. Each accepted word is passed through with
// burst start and end marks; a burst opens after valid_count consecutive energies above
// the threshold and closes after valid_count consecutive energies below it. The block
// accepts one word per cycle while results are taken promptly and no division runs.
// At a burst end with power reporting enabled, the average burst energy comes from a
// restoring divider that retires one quotient bit per cycle over the 40-bit energy
// sum, and input is held off until that division is done.
// Configuration writes take effect on the next cycle and should be made while idle.
module burst_energy_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   bed_req_if.sink                              req_port,
   bed_rsp_if.source                            rsp_port,
   input  logic                                 csr_write_enable,
   input  logic [bed_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bed_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import bed_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic signed [SAMPLE_BITS-1:0] threshold_ff, threshold_in;
   logic [COUNT_BITS-1:0]         valid_count_ff, valid_count_in;
   logic                          power_enable_ff, power_enable_in;

   logic                          in_burst_ff, in_burst_in;
   logic [COUNT_BITS-1:0]         run_count_ff, run_count_in;
   logic [LENGTH_BITS-1:0]        length_ff, length_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;

   bed_state_type                 state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] hold_re_ff, hold_re_in;
   logic signed [SAMPLE_BITS-1:0] hold_im_ff, hold_im_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_re_ff, out_re_in;
   logic signed [SAMPLE_BITS-1:0] out_im_ff, out_im_in;
   logic                          start_ff, start_in;
   logic                          end_ff, end_in;
   logic                          power_valid_ff, power_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;

   logic                          req_ready;
   logic                          accept;
   logic                          div_start;
   logic                          load_direct;
   logic                          start_flag;
   logic                          end_flag;
   logic [COUNT_BITS-1:0]         run_inc;
   logic                          hit;
   logic [LENGTH_BITS-1:0]        length_acc;
   logic [SUM_BITS:0]             sum_wide;
   logic signed [SUM_BITS-1:0]    sum_acc;
   logic signed [SUM_BITS-1:0]    energy_ext;

   bed_div_status_type            div_status;
   logic signed [SAMPLE_BITS-1:0] div_quotient;

   always_comb begin
      threshold_in    = threshold_ff;
      valid_count_in  = valid_count_ff;
      power_enable_in = power_enable_ff;
      if (csr_write_enable) begin
         case (csr_index)
            BED_REG_THRESHOLD:    threshold_in    = csr_write_data[SAMPLE_BITS-1:0];
            BED_REG_VALID_COUNT:  valid_count_in  = csr_write_data[COUNT_BITS-1:0];
            BED_REG_POWER_ENABLE: power_enable_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_port.valid && req_ready;

   always_comb begin
      energy_ext = SUM_BITS'(req_port.energy);
      run_inc    = (run_count_ff == COUNT_MAX) ? COUNT_MAX : run_count_ff + 1'b1;
      hit        = (run_inc >= valid_count_ff);
      length_acc = (&length_ff) ? length_ff : length_ff + 1'b1;
      sum_wide   = {sum_ff[SUM_BITS-1], sum_ff} + {energy_ext[SUM_BITS-1], energy_ext};
      if (&length_ff) begin
         sum_acc = sum_ff;
      end else if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_acc = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                      : {1'b0, {(SUM_BITS - 1){1'b1}}};
      end else begin
         sum_acc = sum_wide[SUM_BITS-1:0];
      end

      in_burst_in  = in_burst_ff;
      run_count_in = run_count_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      start_flag   = 1'b0;
      end_flag     = 1'b0;

      if (accept) begin
         if (!in_burst_ff) begin
            if (req_port.energy > threshold_ff) begin
               if (hit) begin
                  in_burst_in  = 1'b1;
                  run_count_in = '0;
                  length_in    = LENGTH_BITS'(1);
                  sum_in       = energy_ext;
                  start_flag   = 1'b1;
               end else begin
                  run_count_in = run_inc;
               end
            end else begin
               run_count_in = '0;
            end
         end else begin
            length_in = length_acc;
            sum_in    = sum_acc;
            if (req_port.energy < threshold_ff) begin
               if (hit) begin
                  in_burst_in  = 1'b0;
                  run_count_in = '0;
                  end_flag     = 1'b1;
               end else begin
                  run_count_in = run_inc;
               end
            end else begin
               run_count_in = '0;
            end
         end
      end
   end

   assign div_start   = accept && end_flag && power_enable_ff;
   assign load_direct = accept && !div_start;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BED_IDLE: begin
            if (div_start) begin
               state_in = BED_DIVIDE;
            end
         end
         BED_DIVIDE: begin
            if (div_status.done) begin
               state_in = BED_IDLE;
            end
         end
         default: state_in = BED_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         BED_IDLE: req_ready = !rsp_valid_ff || rsp_port.ready;
         default:  req_ready = 1'b0;
      endcase
   end

   always_comb begin
      hold_re_in     = hold_re_ff;
      hold_im_in     = hold_im_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      out_re_in      = out_re_ff;
      out_im_in      = out_im_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      power_valid_in = power_valid_ff;
      avg_in         = avg_ff;

      if (div_start) begin
         hold_re_in = req_port.sample_re;
         hold_im_in = req_port.sample_im;
      end
      if (load_direct) begin
         rsp_valid_in   = 1'b1;
         out_re_in      = req_port.sample_re;
         out_im_in      = req_port.sample_im;
         start_in       = start_flag;
         end_in         = end_flag;
         power_valid_in = 1'b0;
         avg_in         = '0;
      end else if (div_status.done) begin
         rsp_valid_in   = 1'b1;
         out_re_in      = hold_re_ff;
         out_im_in      = hold_im_ff;
         start_in       = 1'b0;
         end_in         = 1'b1;
         power_valid_in = 1'b1;
         avg_in         = div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         valid_count_ff  <= VALID_COUNT_RESET;
         power_enable_ff <= 1'b0;
         in_burst_ff     <= 1'b0;
         run_count_ff    <= '0;
         length_ff       <= '0;
         sum_ff          <= '0;
         state_ff        <= BED_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         threshold_ff    <= threshold_in;
         valid_count_ff  <= valid_count_in;
         power_enable_ff <= power_enable_in;
         in_burst_ff     <= in_burst_in;
         run_count_ff    <= run_count_in;
         length_ff       <= length_in;
         sum_ff          <= sum_in;
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      hold_re_ff     <= hold_re_in;
      hold_im_ff     <= hold_im_in;
      out_re_ff      <= out_re_in;
      out_im_ff      <= out_im_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      power_valid_ff <= power_valid_in;
      avg_ff         <= avg_in;
   end

   bed_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (length_in),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_port.ready       = req_ready;
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.out_re      = out_re_ff;
   assign rsp_port.out_im      = out_im_ff;
   assign rsp_port.burst_start = start_ff;
   assign rsp_port.burst_end   = end_ff;
   assign rsp_port.power_valid = power_valid_ff;
   assign rsp_port.avg_power   = avg_ff;

endmodule

### src/bed_checker.sv
`include "burst_energy_detector_defines.svh"

module bed_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [bed_pkg::SAMPLE_BITS-1:0] out_re,
   input logic signed [bed_pkg::SAMPLE_BITS-1:0] out_im,
   input logic                                 burst_start,
   input logic                                 burst_end,
   input logic                                 power_valid,
   input logic signed [bed_pkg::SAMPLE_BITS-1:0] avg_power
);
   import bed_pkg::*;

   logic [3*SAMPLE_BITS+2:0] rsp_word;

   assign rsp_word = {out_re, out_im, burst_start, burst_end, power_valid, avg_power};

   // A stalled result word keeps its contents.
   `BED_ASSERT_NEXT(rsp_hold_chk, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // A new word is never taken while an untaken result would be overwritten.
   `BED_ASSERT_SAME(no_overwrite_chk, req_valid && req_ready, !rsp_valid || rsp_ready)

   // A burst average only comes with a burst end.
   `BED_ASSERT_SAME(power_at_end_chk, rsp_valid && power_valid, burst_end && !burst_start)

   // Without a reported average the power field reads zero.
   `BED_ASSERT_SAME(avg_zero_chk, rsp_valid && !power_valid, avg_power == '0)

endmodule

bind burst_energy_detector bed_checker u_bed_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .out_re      (rsp_port.out_re),
   .out_im      (rsp_port.out_im),
   .burst_start (rsp_port.burst_start),
   .burst_end   (rsp_port.burst_end),
   .power_valid (rsp_port.power_valid),
   .avg_power   (rsp_port.avg_power)
);
